// File: hw/rtl/sample_to_ascii_decimal_encoder_assert.svh
// assertion macros for the sample to ascii decimal encoder
`ifndef SAMPLE_TO_ASCII_DECIMAL_ENCODER_ASSERT_SVH
`define SAMPLE_TO_ASCII_DECIMAL_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define S2A_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define S2A_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define S2A_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define S2A_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/s2a_pkg.sv
// shared constants and types for the sample to ascii decimal encoder
package s2a_pkg;

    localparam int SampleW = 16;
    localparam int CharW   = 8;
    localparam int DepthW  = 2;
    localparam int MaxChars = 7;
    localparam int CntW    = 3;
    localparam int NumDigits = 5;

    localparam logic [DepthW-1:0] DEPTH_ONE     = 2'd0;
    localparam logic [DepthW-1:0] DEPTH_EIGHT   = 2'd1;
    localparam logic [DepthW-1:0] DEPTH_SIXTEEN = 2'd2;
    localparam logic [DepthW-1:0] DEPTH_RESET   = DEPTH_EIGHT;

    localparam logic [CharW-1:0] CH_ZERO    = 8'h30;
    localparam logic [CharW-1:0] CH_NINE    = 8'h39;
    localparam logic [CharW-1:0] CH_SPACE   = 8'h20;
    localparam logic [CharW-1:0] CH_NEWLINE = 8'h0A;

    // reciprocal constants: floor(v / d) == (v * RECIP) >> SHIFT for any 16-bit v
    localparam int ProdW = 34;
    localparam logic [16:0] RECIP_10    = 17'd52429;
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam logic [16:0] RECIP_1000  = 17'd67109;
    localparam logic [16:0] RECIP_10000 = 17'd107375;
    localparam int Shift10    = 19;
    localparam int Shift100   = 23;
    localparam int Shift1000  = 26;
    localparam int Shift10000 = 30;

    localparam int Q1W = 13;
    localparam int Q2W = 10;
    localparam int Q3W = 7;
    localparam int Q4W = 3;

    typedef struct packed {
        logic [SampleW-1:0] value;
        logic [Q1W-1:0]     q1;
        logic [Q2W-1:0]     q2;
        logic [Q3W-1:0]     q3;
        logic [Q4W-1:0]     q4;
        logic [DepthW-1:0]  depth;
        logic               row_end;
    } t_quot;

endpackage

// File: hw/rtl/sample_to_ascii_decimal_encoder.sv
// a sample's word passes the input register and the quotient register into the character buffer
// throughput: one character per cycle while the output is ready; a sample has 1 to 7
//   characters, or none, and a sample with no characters still passes through the buffer stage
// the output character buffer and its single output port set the sample rate
// reset: synchronous active low, clears all pipeline valids and sets sample depth to 8 bit
// configuration is always ready and takes effect on the next sample taken
`include "sample_to_ascii_decimal_encoder_assert.svh"

module sample_to_ascii_decimal_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [s2a_pkg::DepthW-1:0]    i_cfg_data,       // sample_depth
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [s2a_pkg::SampleW-1:0]   i_s_axis_tdata,   // sample[15:0]
    input  logic                          i_s_axis_tlast,   // row_end
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [s2a_pkg::CharW-1:0]     o_m_axis_tdata,   // text_char[7:0]
    output logic                          o_m_axis_tlast    // last_char
);
    import s2a_pkg::*;

    logic [DepthW-1:0] r_depth;
    logic              quot_valid;
    logic              quot_ready;
    t_quot             quot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_depth <= i_cfg_data;
        end
    end

    s2a_divide u_divide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_sample  (i_s_axis_tdata),
        .i_row_end (i_s_axis_tlast),
        .i_depth   (r_depth),
        .o_valid   (quot_valid),
        .o_quot    (quot),
        .i_ready   (quot_ready)
    );

    s2a_serializer u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (quot_valid),
        .o_ready  (quot_ready),
        .i_quot   (quot),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

    // only digits, space and newline leave the block
    `S2A_ASSERT_SAME(a_char_set, i_clk, i_rst_n, o_m_axis_tvalid,
        (o_m_axis_tdata == CH_SPACE) || (o_m_axis_tdata == CH_NEWLINE) ||
        ((o_m_axis_tdata >= CH_ZERO) && (o_m_axis_tdata <= CH_NINE)),
        "unexpected output character")
    // a sample always closes on a space or a newline
    `S2A_ASSERT_SAME(a_last_sep, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast,
        (o_m_axis_tdata == CH_SPACE) || (o_m_axis_tdata == CH_NEWLINE),
        "last word is not a separator")
    // newline is only ever the final word of a sample
    `S2A_ASSERT_SAME(a_newline_last, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tdata == CH_NEWLINE), o_m_axis_tlast,
        "newline not marked last")
    // after a non-final word is taken another word of the same sample follows
    `S2A_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n,
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid,
        "word run broken before last")

endmodule

// File: hw/rtl/s2a_divide.sv
// input register and reciprocal divide stage producing decimal quotients
module s2a_divide (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [s2a_pkg::SampleW-1:0]   i_sample,
    input  logic                          i_row_end,
    input  logic [s2a_pkg::DepthW-1:0]    i_depth,
    output logic                          o_valid,
    output s2a_pkg::t_quot                o_quot,
    input  logic                          i_ready
);
    import s2a_pkg::*;

    logic               r_s1_valid;
    logic [SampleW-1:0] r_s1_value;
    logic [DepthW-1:0]  r_s1_depth;
    logic               r_s1_row_end;
    logic               r_s2_valid;
    t_quot              r_quot;

    logic               s1_ready;
    logic               s2_ready;
    logic [SampleW-1:0] n_value;
    logic [ProdW-1:0]   p10;
    logic [ProdW-1:0]   p100;
    logic [ProdW-1:0]   p1000;
    logic [ProdW-1:0]   p10000;
    t_quot              n_quot;

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r_s2_valid;
    assign o_quot   = r_quot;

    // narrow modes use only the low byte
    assign n_value = (i_depth == DEPTH_SIXTEEN) ? i_sample : {8'h00, i_sample[7:0]};

    assign p10    = ProdW'(r_s1_value) * ProdW'(RECIP_10);
    assign p100   = ProdW'(r_s1_value) * ProdW'(RECIP_100);
    assign p1000  = ProdW'(r_s1_value) * ProdW'(RECIP_1000);
    assign p10000 = ProdW'(r_s1_value) * ProdW'(RECIP_10000);

    always_comb begin
        n_quot.value   = r_s1_value;
        n_quot.q1      = p10[Shift10 +: Q1W];
        n_quot.q2      = p100[Shift100 +: Q2W];
        n_quot.q3      = p1000[Shift1000 +: Q3W];
        n_quot.q4      = p10000[Shift10000 +: Q4W];
        n_quot.depth   = r_s1_depth;
        n_quot.row_end = r_s1_row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_value   <= n_value;
            r_s1_depth   <= i_depth;
            r_s1_row_end <= i_row_end;
        end
        if (s2_ready && r_s1_valid) begin
            r_quot <= n_quot;
        end
    end

endmodule

// File: hw/rtl/s2a_serializer.sv
// digit extraction, character buffer and one-character-per-cycle output while i_tready is high
module s2a_serializer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  s2a_pkg::t_quot              i_quot,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [s2a_pkg::CharW-1:0]   o_tdata,
    output logic                        o_tlast
);
    import s2a_pkg::*;

    logic [CharW-1:0] r_chars [MaxChars];
    logic [CntW-1:0]  r_cnt;

    logic [CharW-1:0] n_chars [MaxChars];
    logic [CntW-1:0]  n_cnt;
    logic [3:0]       dig [NumDigits];
    logic [CntW-1:0]  nb;
    logic             has_sp;
    logic [SampleW-1:0] rem0;
    logic [Q1W-1:0]     rem1;
    logic [Q2W-1:0]     rem2;
    logic [Q3W-1:0]     rem3;
    logic             load;
    logic             fire;

    assign fire     = o_tvalid && i_tready;
    assign o_ready  = (r_cnt == '0) || ((r_cnt == CntW'(1)) && i_tready);
    assign load     = i_valid && o_ready;
    assign o_tvalid = (r_cnt != '0);
    assign o_tdata  = r_chars[0];
    assign o_tlast  = (r_cnt == CntW'(1));

    // each digit is a quotient minus ten times the next one
    assign rem0 = i_quot.value - (SampleW'(i_quot.q1) * SampleW'(10));
    assign rem1 = i_quot.q1 - (Q1W'(i_quot.q2) * Q1W'(10));
    assign rem2 = i_quot.q2 - (Q2W'(i_quot.q3) * Q2W'(10));
    assign rem3 = i_quot.q3 - (Q3W'(i_quot.q4) * Q3W'(10));

    always_comb begin
        dig[0] = rem0[3:0];
        dig[1] = rem1[3:0];
        dig[2] = rem2[3:0];
        dig[3] = rem3[3:0];
        dig[4] = {1'b0, i_quot.q4};
        has_sp = 1'b1;
        case (i_quot.depth)
            DEPTH_ONE: begin
                // zero sample prints one, nonzero prints zero
                dig[0] = (i_quot.value == '0) ? 4'd1 : 4'd0;
                nb     = CntW'(1);
            end
            DEPTH_EIGHT, DEPTH_SIXTEEN: begin
                if (i_quot.q4 != '0) begin
                    nb = CntW'(5);
                end else if (i_quot.q3 != '0) begin
                    nb = CntW'(4);
                end else if (i_quot.q2 != '0) begin
                    nb = CntW'(3);
                end else if (i_quot.q1 != '0) begin
                    nb = CntW'(2);
                end else begin
                    nb = CntW'(1);
                end
            end
            default: begin
                nb     = '0;
                has_sp = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < MaxChars; i++) begin
            if (CntW'(i) < nb) begin
                n_chars[i] = CH_ZERO + {4'h0, dig[nb - CntW'(1) - CntW'(i)]};
            end else if ((CntW'(i) == nb) && has_sp) begin
                n_chars[i] = CH_SPACE;
            end else begin
                n_chars[i] = CH_NEWLINE;
            end
        end
        n_cnt = nb + CntW'(has_sp) + CntW'(i_quot.row_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= n_cnt;
        end else if (fire) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_chars <= n_chars;
        end else if (fire) begin
            for (int i = 0; i < MaxChars - 1; i++) begin
                r_chars[i] <= r_chars[i+1];
            end
        end
    end

endmodule

// File: tb/testbench.sv
// self-checking testbench for the sample to ascii decimal encoder
`timescale 1ns / 100ps

module testbench;
    import s2a_pkg::*;

    localparam logic [DepthW-1:0] DEPTH_UNUSED = 2'd3;
    localparam int StallLimit = 2000;
    localparam int HoldCycles = 150;
    localparam int DrainCycles = 8;
    localparam int NumPhases = 12;
    localparam int PhaseItems = 30;

    typedef struct packed {
        logic [CharW-1:0] text_char;
        logic             last_char;
    } char_word_t;

    // predicts the character stream and checks each character word against it
    class text_scoreboard;
        char_word_t        pending_chars[$];
        logic [DepthW-1:0] depth = DEPTH_RESET;
        int                errors = 0;
        int                chars_checked = 0;
        int                samples_taken = 0;

        function void set_depth(logic [DepthW-1:0] d);
            depth = d;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        function void note_sample(logic [SampleW-1:0] smp, logic row_end);
            logic [CharW-1:0] digits[NumDigits];
            char_word_t       chars[$];
            int               n;
            int               v;
            samples_taken++;
            case (depth)
                DEPTH_ONE: begin
                    chars.push_back({(smp[7:0] == 8'd0) ? CH_ZERO + 8'd1 : CH_ZERO, 1'b0});
                    chars.push_back({CH_SPACE, 1'b0});
                end
                DEPTH_EIGHT, DEPTH_SIXTEEN: begin
                    v = (depth == DEPTH_EIGHT) ? int'(smp[7:0]) : int'(smp);
                    n = 0;
                    do begin
                        digits[n] = CH_ZERO + 8'(v % 10);
                        v = v / 10;
                        n++;
                    end while (v != 0);
                    for (int i = n - 1; i >= 0; i--) chars.push_back({digits[i], 1'b0});
                    chars.push_back({CH_SPACE, 1'b0});
                end
                default: ;
            endcase
            if (row_end) chars.push_back({CH_NEWLINE, 1'b0});
            if (chars.size() > 0) chars[chars.size() - 1].last_char = 1'b1;
            foreach (chars[i]) pending_chars.push_back(chars[i]);
        endfunction

        function void check_char(logic [CharW-1:0] ch, logic last);
            char_word_t want;
            chars_checked++;
            if (pending_chars.size() == 0) begin
                $error("unexpected character word %h last %b", ch, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.text_char) begin
                $error("text_char: expected %h, got %h", want.text_char, ch);
                errors++;
            end
            if (last !== want.last_char) begin
                $error("last_char: expected %b, got %b", want.last_char, last);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [DepthW-1:0]   cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic [SampleW-1:0]  s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tready = 1'b0;
    logic                o_cfg_ready;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [CharW-1:0]    o_m_axis_tdata;
    logic                o_m_axis_tlast;

    text_scoreboard sb = new();

    int  snd_idle = 32;
    int  rcv_idle = 51;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  depth_writes = 0;

    sample_to_ascii_decimal_encoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 clk = ~clk;

    // handshake monitor and stall watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready) sb.set_depth(cfg_data);
            if (s_tvalid && o_s_axis_tready) sb.note_sample(s_tdata, s_tlast);
            if (o_m_axis_tvalid && m_tready) sb.check_char(o_m_axis_tdata, o_m_axis_tlast);
            if ((cfg_valid && o_cfg_ready) || (s_tvalid && o_s_axis_tready)
                    || (o_m_axis_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= StallLimit) begin
                $display("timeout: no word moved for %0d cycles", StallLimit);
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // output side: random backpressure, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // valid stays high on return so back-to-back words need no drop
    task automatic send_sample(input logic [SampleW-1:0] smp, input logic row_end);
        if ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= row_end;
        @(posedge clk);
        while (!o_s_axis_tready) @(posedge clk);
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        // let the monitor note the last word taken before looking at the queue
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        // a sample with no characters may still sit in the pipeline
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_depth(input logic [DepthW-1:0] d);
        drain_outputs();
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        depth_writes++;
    endtask

    function automatic logic [SampleW-1:0] pick_sample();
        logic [SampleW-1:0] edges[12] = '{0, 9, 10, 99, 100, 255, 256, 999, 1000,
                                          9999, 10000, 65535};
        case ($urandom_range(3))
            0: return SampleW'($urandom);
            1: return SampleW'($urandom_range(255));
            2: return edges[$urandom_range(11)];
            default: return SampleW'($urandom_range(20));
        endcase
    endfunction

    initial begin
        logic [DepthW-1:0] phase_depth[NumPhases] = '{DEPTH_SIXTEEN, DEPTH_ONE, DEPTH_EIGHT,
            DEPTH_UNUSED, DEPTH_SIXTEEN, DEPTH_EIGHT, DEPTH_ONE, DEPTH_SIXTEEN,
            DEPTH_UNUSED, DEPTH_EIGHT, DEPTH_SIXTEEN, DEPTH_ONE};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // eight-bit mode straight out of reset, upper byte must be dropped
        send_sample(16'd0, 1'b0);
        send_sample(16'd255, 1'b0);
        send_sample(16'hAB12, 1'b0);
        send_sample(16'd9, 1'b0);
        send_sample(16'd10, 1'b0);
        send_sample(16'd99, 1'b0);
        send_sample(16'd100, 1'b1);

        write_depth(DEPTH_ONE);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFF00, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'h0180, 1'b1);

        write_depth(DEPTH_SIXTEEN);
        send_sample(16'd0, 1'b0);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd9999, 1'b0);
        send_sample(16'd10000, 1'b0);
        send_sample(16'h8000, 1'b1);

        // unused depth code: no characters, newline only at row end
        write_depth(DEPTH_UNUSED);
        send_sample(16'd5, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd7, 1'b1);

        for (int p = 0; p < NumPhases; p++) begin
            write_depth(phase_depth[p]);
            case (p / 4)
                0: begin snd_idle = 32; rcv_idle = 51; end
                1: begin snd_idle = 51; rcv_idle = 32; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            // stall the output long enough to back up into the input
            if (p == 1 || p == 10) hold_req = 1'b1;
            for (int i = 0; i < PhaseItems; i++) begin
                send_sample(pick_sample(), ($urandom_range(4) == 0));
            end
        end

        drain_outputs();
        $display("covered %0d samples, %0d characters checked, %0d depth writes",
                 sb.samples_taken, sb.chars_checked, depth_writes);
        $display("depth modes one, eight, sixteen and unused with three stall patterns");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sample_to_ascii_decimal_encoder.f
+incdir+hw/rtl
hw/rtl/s2a_pkg.sv
hw/rtl/s2a_divide.sv
hw/rtl/s2a_serializer.sv
hw/rtl/sample_to_ascii_decimal_encoder.sv
tb/testbench.sv
